// ===== hw/rtl/ssc_pkg.sv =====
package ssc_pkg;

    localparam int SSC_MAX_NODES = 1024;
    localparam int SSC_MAX_EDGES = 4096;

    // Fixed field widths of the stream and configuration ports.
    localparam int SSC_ID_W    = 10;
    localparam int SSC_CNT_W   = 11;
    localparam int SSC_IN_W    = 24;
    localparam int SSC_OUT_W   = 24;
    localparam logic [SSC_CNT_W-1:0] SSC_NODE_COUNT_RST = 11'd1024;

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_RUN      = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_OUTER,
        S_OUTER_CHK,
        S_ENTER,
        S_ENTER2,
        S_TOP,
        S_TOP2,
        S_EDGE,
        S_EDGE2,
        S_EDGE3,
        S_FIN,
        S_POP,
        S_POP2,
        S_POPEND,
        S_RET,
        S_RET2,
        S_RET3,
        S_C_NODE,
        S_C_NODE2,
        S_C_EDGE,
        S_C_EDGE2,
        S_C_EDGE3,
        S_SUM,
        S_SUM2,
        S_OUT,
        S_CLR
    } t_state;

endpackage

// ===== hw/rtl/ssc_ram.sv =====
module ssc_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/source_scc_counter.sv =====
// Counts the source components of a directed graph. Edges arrive as beats with
// tuser low and are stored in per-node chains, one beat per cycle while the
// block is idle; an edge whose store is full is dropped and reported with the
// next result. A beat with tuser high runs Tarjan's strongly connected
// component search over the first node_count nodes, counts the components that
// no other component enters, returns one result beat and clears the graph.
// A clearing pass over all MAX_NODES node slots ends each run; the same pass
// runs after reset. The search keeps its node state in a memory with one read
// port and one write port. The result waits in an output register until it
// is taken.
module source_scc_counter
    import ssc_pkg::*;
#(
    parameter int MAX_NODES = SSC_MAX_NODES,
    parameter int MAX_EDGES = SSC_MAX_EDGES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: node_count.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [SSC_CNT_W-1:0] i_cfg_data,
    // tdata: edge_source[9:0], edge_target[19:10], zero fill [23:20].
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [SSC_IN_W-1:0]  s_axis_tdata,
    // tuser: op.
    input  logic                 s_axis_tuser,
    // tdata: source_components[10:0], component_total[21:11],
    // edges_dropped[22], zero fill [23].
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [SSC_OUT_W-1:0] m_axis_tdata
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = NW + 1;
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int LW  = $clog2(MAX_EDGES + 1);
    localparam int NDW = 2 + 3 * NW;
    localparam int EDW = SSC_ID_W + LW;
    localparam int FW  = NW + LW;
    // Node word layout: visited, on member stack, discovery rank, low rank,
    // component.
    localparam int B_VIS = 3 * NW + 1;
    localparam int B_ONS = 3 * NW;
    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_EDGES);

    t_state r_state, n_state;
    logic [CW-1:0] r_i, n_i, r_n, n_n;
    logic [CW-1:0] r_rank, n_rank, r_cc, n_cc, r_top, n_top, r_depth, n_depth;
    logic [CW-1:0] r_srcs, n_srcs;
    logic [NW-1:0] r_v, n_v, r_u, n_u, r_w, n_w, r_lw, n_lw, r_ulow, n_ulow;
    logic [NW-1:0] r_ci, n_ci;
    logic [LW-1:0] r_e, n_e, r_held, n_held;
    logic          r_popped, n_popped, r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;
    logic [SSC_OUT_W-1:0] r_out_data, n_out_data;
    logic [SSC_CNT_W-1:0] r_cfg;
    logic          r_s2_v, r_s2_hit, n_s2_hit;
    logic [SSC_ID_W-1:0] r_s2_src, r_s2_dst;

    logic            head_we, node_we, ent_we, mstk_we, frm_we, edge_we;
    logic [NW-1:0]   head_wa, head_ra, node_wa, node_ra, ent_wa, ent_ra;
    logic [NW-1:0]   mstk_wa, mstk_ra, frm_wa, frm_ra;
    logic [EW-1:0]   edge_wa, edge_ra;
    logic [LW-1:0]   head_wd, head_rd;
    logic [NDW-1:0]  node_wd, node_rd;
    logic            ent_wd, ent_rd;
    logic [NW-1:0]   mstk_wd, mstk_rd;
    logic [FW-1:0]   frm_wd, frm_rd;
    logic [EDW-1:0]  edge_wd, edge_rd;

    logic          in_acc, s2_wr;
    logic [SSC_ID_W-1:0] in_src, in_dst, e_dest;
    logic [LW-1:0] e_link, f_next;
    logic [NW-1:0] f_node, nd_low, nd_disc, nd_comp;

    ssc_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDW)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_wa), .i_wdata(edge_wd),
        .i_raddr(edge_ra), .o_rdata(edge_rd));
    ssc_ram #(.DEPTH(MAX_NODES), .WIDTH(LW)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(head_ra), .o_rdata(head_rd));
    ssc_ram #(.DEPTH(MAX_NODES), .WIDTH(NDW)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_wa), .i_wdata(node_wd),
        .i_raddr(node_ra), .o_rdata(node_rd));
    ssc_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_ent (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_wa), .i_wdata(ent_wd),
        .i_raddr(ent_ra), .o_rdata(ent_rd));
    ssc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_mstk (
        .i_clk(i_clk), .i_we(mstk_we), .i_waddr(mstk_wa), .i_wdata(mstk_wd),
        .i_raddr(mstk_ra), .o_rdata(mstk_rd));
    ssc_ram #(.DEPTH(MAX_NODES), .WIDTH(FW)) u_frm (
        .i_clk(i_clk), .i_we(frm_we), .i_waddr(frm_wa), .i_wdata(frm_wd),
        .i_raddr(frm_ra), .o_rdata(frm_rd));

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_src  = s_axis_tdata[SSC_ID_W-1:0];
    assign in_dst  = s_axis_tdata[2*SSC_ID_W-1:SSC_ID_W];
    assign e_dest  = edge_rd[EDW-1:LW];
    assign e_link  = edge_rd[LW-1:0];
    assign f_node  = frm_rd[FW-1:LW];
    assign f_next  = frm_rd[LW-1:0];
    assign nd_disc = node_rd[3*NW-1:2*NW];
    assign nd_low  = node_rd[2*NW-1:NW];
    assign nd_comp = node_rd[NW-1:0];

    // Second half of an edge load: link the new edge in front of its chain.
    assign s2_wr = r_s2_v && (32'(r_s2_src) < MAX_NODES) && (32'(r_held) < MAX_EDGES);

    always_comb begin
        n_state = r_state;
        n_i = r_i;  n_n = r_n;  n_rank = r_rank;  n_cc = r_cc;
        n_top = r_top;  n_depth = r_depth;  n_srcs = r_srcs;
        n_v = r_v;  n_u = r_u;  n_w = r_w;  n_lw = r_lw;  n_ulow = r_ulow;
        n_ci = r_ci;  n_e = r_e;  n_popped = r_popped;
        n_held = r_held;  n_ovf = r_ovf;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data = r_out_data;

        edge_we = 1'b0;  edge_wa = EW'(r_held);
        edge_wd = {r_s2_dst, (r_s2_hit ? LW'(r_held - LW'(1)) : head_rd)};
        edge_ra = EW'(r_e);
        head_we = 1'b0;  head_wa = NW'(r_s2_src);  head_wd = r_held;
        head_ra = NW'(in_src);
        node_we = 1'b0;  node_wa = r_v;  node_wd = node_rd;  node_ra = r_v;
        ent_we = 1'b0;  ent_wa = nd_comp;  ent_wd = 1'b1;  ent_ra = NW'(r_i);
        mstk_we = 1'b0;  mstk_wa = NW'(r_top);  mstk_wd = r_v;
        mstk_ra = NW'(r_top - CW'(1));
        frm_we = 1'b0;  frm_wa = NW'(r_depth);  frm_wd = {r_v, head_rd};
        frm_ra = NW'(r_depth - CW'(1));

        n_s2_hit = r_s2_v && s2_wr && (r_s2_src == in_src);
        if (s2_wr) begin
            edge_we = 1'b1;
            head_we = 1'b1;
            n_held  = r_held + LW'(1);
        end else if (r_s2_v && (32'(r_s2_src) < MAX_NODES)) begin
            n_ovf = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && s_axis_tuser == OP_RUN) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_i = '0;
                n_n = (32'(r_cfg) > MAX_NODES) ? CW'(MAX_NODES) : CW'(r_cfg);
                n_state = S_OUTER;
            end
            S_OUTER: begin
                if (r_i >= r_n) begin
                    n_i = '0;
                    n_state = S_C_NODE;
                end else begin
                    node_ra = NW'(r_i);
                    n_state = S_OUTER_CHK;
                end
            end
            S_OUTER_CHK: begin
                if (node_rd[B_VIS]) begin
                    n_i = r_i + CW'(1);
                    n_state = S_OUTER;
                end else begin
                    n_v = NW'(r_i);
                    n_state = S_ENTER;
                end
            end
            S_ENTER: begin
                node_we = 1'b1;
                node_wa = r_v;
                node_wd = {2'b11, NW'(r_rank), NW'(r_rank), NW'(0)};
                mstk_we = 1'b1;
                n_top  = r_top + CW'(1);
                n_rank = r_rank + CW'(1);
                head_ra = r_v;
                n_state = S_ENTER2;
            end
            S_ENTER2: begin
                frm_we  = 1'b1;
                n_depth = r_depth + CW'(1);
                n_state = S_TOP;
            end
            S_TOP: begin
                if (r_depth == '0) begin
                    n_i = r_i + CW'(1);
                    n_state = S_OUTER;
                end else begin
                    n_state = S_TOP2;
                end
            end
            S_TOP2: begin
                n_u = f_node;
                if (f_next != NULL_LINK) begin
                    edge_ra = EW'(f_next);
                    n_state = S_EDGE;
                end else begin
                    node_ra = f_node;
                    n_state = S_FIN;
                end
            end
            S_EDGE: begin
                // Advance the frame's edge cursor before looking at the target.
                frm_we = 1'b1;
                frm_wa = NW'(r_depth - CW'(1));
                frm_wd = {r_u, e_link};
                if (32'(e_dest) >= 32'(r_n)) begin
                    n_state = S_TOP;
                end else begin
                    n_w = NW'(e_dest);
                    node_ra = NW'(e_dest);
                    n_state = S_EDGE2;
                end
            end
            S_EDGE2: begin
                if (!node_rd[B_VIS]) begin
                    n_v = r_w;
                    n_state = S_ENTER;
                end else if (node_rd[B_ONS]) begin
                    n_lw = nd_low;
                    node_ra = r_u;
                    n_state = S_EDGE3;
                end else begin
                    n_state = S_TOP;
                end
            end
            S_EDGE3: begin
                if (r_lw < nd_low) begin
                    node_we = 1'b1;
                    node_wa = r_u;
                    node_wd = {node_rd[NDW-1:2*NW], r_lw, nd_comp};
                end
                n_state = S_TOP;
            end
            S_FIN: begin
                n_ulow = nd_low;
                n_popped = (nd_low == nd_disc);
                n_state = (nd_low == nd_disc) ? S_POP : S_RET;
            end
            S_POP: begin
                if (r_top == '0) begin
                    n_state = S_POPEND;
                end else begin
                    n_top = r_top - CW'(1);
                    n_state = S_POP2;
                end
            end
            S_POP2: begin
                // Of a popped node, only the flags and the component id are read again.
                node_we = 1'b1;
                node_wa = mstk_rd;
                node_wd = {2'b10, NW'(0), NW'(0), NW'(r_cc)};
                n_state = (mstk_rd == r_u) ? S_POPEND : S_POP;
            end
            S_POPEND: begin
                n_cc = r_cc + CW'(1);
                n_state = S_RET;
            end
            S_RET: begin
                n_depth = r_depth - CW'(1);
                if (r_depth > CW'(1) && !r_popped) begin
                    frm_ra = NW'(r_depth - CW'(2));
                    n_state = S_RET2;
                end else begin
                    n_state = S_TOP;
                end
            end
            S_RET2: begin
                n_w = f_node;
                node_ra = f_node;
                n_state = S_RET3;
            end
            S_RET3: begin
                if (r_ulow < nd_low) begin
                    node_we = 1'b1;
                    node_wa = r_w;
                    node_wd = {node_rd[NDW-1:2*NW], r_ulow, nd_comp};
                end
                n_state = S_TOP;
            end
            S_C_NODE: begin
                if (r_i >= r_n) begin
                    n_i = '0;
                    n_state = S_SUM;
                end else begin
                    head_ra = NW'(r_i);
                    node_ra = NW'(r_i);
                    n_state = S_C_NODE2;
                end
            end
            S_C_NODE2: begin
                n_e  = head_rd;
                n_ci = nd_comp;
                n_state = S_C_EDGE;
            end
            S_C_EDGE: begin
                if (r_e == NULL_LINK) begin
                    n_i = r_i + CW'(1);
                    n_state = S_C_NODE;
                end else begin
                    n_state = S_C_EDGE2;
                end
            end
            S_C_EDGE2: begin
                n_e = e_link;
                if (32'(e_dest) < 32'(r_n)) begin
                    node_ra = NW'(e_dest);
                    n_state = S_C_EDGE3;
                end else begin
                    n_state = S_C_EDGE;
                end
            end
            S_C_EDGE3: begin
                ent_we = (nd_comp != r_ci);
                n_state = S_C_EDGE;
            end
            S_SUM: begin
                n_state = (r_i >= r_cc) ? S_OUT : S_SUM2;
            end
            S_SUM2: begin
                if (!ent_rd) begin
                    n_srcs = r_srcs + CW'(1);
                end
                n_i = r_i + CW'(1);
                n_state = S_SUM;
            end
            S_OUT: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_ovf, SSC_CNT_W'(r_cc), SSC_CNT_W'(r_srcs)};
                    n_i = '0;
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                head_we = 1'b1;
                head_wa = NW'(r_i);
                head_wd = NULL_LINK;
                node_we = 1'b1;
                node_wa = NW'(r_i);
                node_wd = '0;
                ent_we  = 1'b1;
                ent_wa  = NW'(r_i);
                ent_wd  = 1'b0;
                n_i = r_i + CW'(1);
                if (r_i == CW'(MAX_NODES - 1)) begin
                    n_held = '0;  n_ovf = 1'b0;  n_top = '0;  n_depth = '0;
                    n_rank = '0;  n_cc = '0;  n_srcs = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_i <= '0;  r_n <= '0;  r_rank <= '0;  r_cc <= '0;
            r_top <= '0;  r_depth <= '0;  r_srcs <= '0;
            r_held <= '0;  r_ovf <= 1'b0;  r_popped <= 1'b0;
            r_out_valid <= 1'b0;
            r_s2_v <= 1'b0;  r_s2_hit <= 1'b0;
            r_cfg <= SSC_NODE_COUNT_RST;
        end else begin
            r_state <= n_state;
            r_i <= n_i;  r_n <= n_n;  r_rank <= n_rank;  r_cc <= n_cc;
            r_top <= n_top;  r_depth <= n_depth;  r_srcs <= n_srcs;
            r_held <= n_held;  r_ovf <= n_ovf;  r_popped <= n_popped;
            r_out_valid <= n_out_valid;
            r_s2_v <= in_acc && (s_axis_tuser == OP_ADD_EDGE);
            r_s2_hit <= n_s2_hit;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;  r_u <= n_u;  r_w <= n_w;  r_lw <= n_lw;  r_ulow <= n_ulow;
        r_ci <= n_ci;  r_e <= n_e;
        r_out_data <= n_out_data;
        r_s2_src <= in_src;
        r_s2_dst <= in_dst;
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= MAX_EDGES)
        else $error("edge count beyond store size");
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= MAX_NODES && 32'(r_top) <= MAX_NODES)
        else $error("stack depth beyond node count");
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR && n_state == S_IDLE) |=>
        (r_held == '0 && r_cc == '0 && r_depth == '0 && !r_ovf))
        else $error("graph state not cleared");
    a_run_idle_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_C_NODE) |-> (r_depth == '0))
        else $error("call stack not empty after search");
`endif

endmodule
